// ===== hdl/lfu_pkg.sv =====
// ----------------------------------------------------------------------------
// LFU tag table package
// Word types of the command and result channels, command and status codes,
// and the sequencer state type shared by the LFU tag table.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int KEY_W   = 32;
    localparam int COUNT_W = 16;
    localparam int SLOT_W  = 4;
    localparam int LIMIT_W = 5;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    localparam logic [1:0] CMD_ACCESS = 2'd0;
    localparam logic [1:0] CMD_ZERO   = 2'd1;
    localparam logic [1:0] CMD_INVAL  = 2'd2;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_NO_VIC = 2'd1;
    localparam logic [1:0] STATUS_FULL   = 2'd2;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [KEY_W-1:0] key;
    } t_in_word;

    typedef struct packed {
        logic               hit;
        logic               added;
        logic [SLOT_W-1:0]  slot;
        logic               evicted;
        logic [KEY_W-1:0]   evicted_key;
        logic [COUNT_W-1:0] use_count;
        logic [1:0]         status;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_VICTIM,
        ST_CLEAR,
        ST_INVAL,
        ST_UPDATE,
        ST_DONE
    } t_state;

endpackage

// ===== hdl/lfu_cache_tag_policy.sv =====
// ----------------------------------------------------------------------------
// LFU tag table
// Fully associative table of key tags with saturating use counts, victim
// selection by lowest count and a ring of recently inserted keys.
// ----------------------------------------------------------------------------
// An access walks the memory one entry per cycle: a lookup walk that stops on
// a hit, then a victim walk over all entries when an eviction is due, then an
// update step. Zeroing walks every entry, invalidate clears all valid bits at
// once, and the unused code goes straight to the result.
// One word at a time, the next taken once the result is in the output register.
// Reset clears the valid bits, ring and output valid, and sets the limit to 16.
module lfu_cache_tag_policy
    import lfu_pkg::*;
#(
    parameter int ENTRIES      = 16,
    parameter int RECENT_DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_word             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_word            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [LIMIT_W-1:0]   i_cfg_data
);

    // Index, fill and ring widths all follow from the two depths.
    localparam int IW  = $clog2(ENTRIES);
    localparam int FW  = $clog2(ENTRIES + 1);
    localparam int CW  = (FW > LIMIT_W) ? FW : LIMIT_W;
    localparam int XW  = (IW > SLOT_W) ? IW : SLOT_W;
    localparam int RHW = (RECENT_DEPTH > 1) ? $clog2(RECENT_DEPTH) : 1;
    localparam int RFW = $clog2(RECENT_DEPTH + 1);

    localparam logic [IW-1:0]      LAST_IDX  = IW'(ENTRIES - 1);
    localparam logic [RHW-1:0]     LAST_RING = RHW'(RECENT_DEPTH - 1);
    localparam logic [RFW-1:0]     RING_FULL = RFW'(RECENT_DEPTH);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Sequencer and captured command.
    t_state               r_state, n_state;
    logic [IW-1:0]        r_idx, n_idx;
    logic [KEY_W-1:0]     r_key;
    logic [LIMIT_W-1:0]   r_limit;

    // Results of the lookup walk.
    logic [FW-1:0]        r_fill, n_fill;
    logic                 r_found, n_found;
    logic [IW-1:0]        r_found_idx, n_found_idx;
    logic [COUNT_W-1:0]   r_found_cnt, n_found_cnt;
    logic                 r_free_ok, n_free_ok;
    logic [IW-1:0]        r_free_idx, n_free_idx;
    logic                 r_need_evict, n_need_evict;

    // Best victim candidate of the victim walk.
    logic                 r_vic_ok, n_vic_ok;
    logic [IW-1:0]        r_vic_idx, n_vic_idx;
    logic [KEY_W-1:0]     r_vic_key, n_vic_key;
    logic [COUNT_W-1:0]   r_vic_cnt, n_vic_cnt;

    // Table storage. Valid bits are flops; keys and counts sit in a memory
    // with one write and one registered read port.
    logic [ENTRIES-1:0]   r_valid, n_valid;
    logic [KEY_W-1:0]     mem_key [ENTRIES];
    logic [COUNT_W-1:0]   mem_cnt [ENTRIES];
    logic [KEY_W-1:0]     r_rd_key;
    logic [COUNT_W-1:0]   r_rd_cnt;
    logic                 wr_key_en, wr_cnt_en;
    logic [IW-1:0]        wr_addr;
    logic [KEY_W-1:0]     wr_key;
    logic [COUNT_W-1:0]   wr_cnt;

    // Ring of recently inserted keys.
    logic [KEY_W-1:0]     r_ring [RECENT_DEPTH];
    logic [RHW-1:0]       r_ring_head, n_ring_head;
    logic [RFW-1:0]       r_ring_fill, n_ring_fill;
    logic                 ring_push;
    logic                 ring_hit;

    // Result being built, its slot index, and the output register.
    t_out_word            r_res, n_res;
    logic [IW-1:0]        r_res_slot, n_res_slot;
    t_out_word            r_out;
    logic                 r_out_vld;

    logic                 in_fire;
    logic                 out_free;
    logic                 cur_valid;
    logic                 last_idx;
    logic                 better;
    logic                 evict_here;
    logic [FW-1:0]        fill_inc;
    logic [XW-1:0]        slot_ext;

    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_vld || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    assign cur_valid = r_valid[r_idx];
    assign last_idx  = (r_idx == LAST_IDX);
    assign fill_inc  = r_fill + FW'(1);

    // The key read this cycle is compared with every live ring entry at once.
    always_comb begin
        ring_hit = 1'b0;
        for (int i = 0; i < RECENT_DEPTH; i++) begin
            if ((RFW'(i) < r_ring_fill) && (r_ring[i] == r_rd_key)) begin
                ring_hit = 1'b1;
            end
        end
    end

    // Lower count wins; on equal counts the smaller key wins.
    assign better = !r_vic_ok || (r_rd_cnt < r_vic_cnt) ||
                    ((r_rd_cnt == r_vic_cnt) && (r_rd_key < r_vic_key));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    case (i_in_data.cmd)
                        CMD_ACCESS: n_state = ST_LOOKUP;
                        CMD_ZERO:   n_state = ST_CLEAR;
                        CMD_INVAL:  n_state = ST_INVAL;
                        default:    n_state = ST_DONE;
                    endcase
                end
            end
            ST_LOOKUP: begin
                if (cur_valid && (r_rd_key == r_key)) begin
                    n_state = ST_UPDATE;
                end else if (last_idx) begin
                    n_state = n_need_evict ? ST_VICTIM : ST_UPDATE;
                end
            end
            ST_VICTIM: begin
                if (last_idx) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_CLEAR: begin
                if (last_idx) begin
                    n_state = ST_DONE;
                end
            end
            ST_INVAL:  n_state = ST_DONE;
            ST_UPDATE: n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath controls and next values.
    always_comb begin
        n_idx        = '0;
        n_fill       = r_fill;
        n_found      = r_found;
        n_found_idx  = r_found_idx;
        n_found_cnt  = r_found_cnt;
        n_free_ok    = r_free_ok;
        n_free_idx   = r_free_idx;
        n_need_evict = r_need_evict;
        n_vic_ok     = r_vic_ok;
        n_vic_idx    = r_vic_idx;
        n_vic_key    = r_vic_key;
        n_vic_cnt    = r_vic_cnt;
        n_valid      = r_valid;
        n_res        = r_res;
        n_res_slot   = r_res_slot;
        n_ring_head  = r_ring_head;
        n_ring_fill  = r_ring_fill;
        ring_push    = 1'b0;
        wr_key_en    = 1'b0;
        wr_cnt_en    = 1'b0;
        wr_addr      = r_idx;
        wr_key       = r_key;
        wr_cnt       = '0;
        evict_here   = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_fill       = '0;
                    n_found      = 1'b0;
                    n_free_ok    = 1'b0;
                    n_need_evict = 1'b0;
                    n_vic_ok     = 1'b0;
                    n_res        = '0;
                    n_res_slot   = '0;
                end
            end
            ST_LOOKUP: begin
                n_idx = r_idx + IW'(1);
                if (cur_valid) begin
                    n_fill = fill_inc;
                    if (r_rd_key == r_key) begin
                        n_found     = 1'b1;
                        n_found_idx = r_idx;
                        n_found_cnt = r_rd_cnt;
                        n_idx       = '0;
                    end
                end else if (!r_free_ok) begin
                    n_free_ok  = 1'b1;
                    n_free_idx = r_idx;
                end
                if (last_idx) begin
                    n_idx        = '0;
                    n_need_evict = (r_limit != '0) &&
                                   (CW'(n_fill) >= CW'(r_limit));
                end
            end
            ST_VICTIM: begin
                n_idx = last_idx ? '0 : r_idx + IW'(1);
                if (cur_valid && !ring_hit && better) begin
                    n_vic_ok  = 1'b1;
                    n_vic_idx = r_idx;
                    n_vic_key = r_rd_key;
                    n_vic_cnt = r_rd_cnt;
                end
            end
            ST_CLEAR: begin
                n_idx     = last_idx ? '0 : r_idx + IW'(1);
                wr_cnt_en = 1'b1;
                wr_cnt    = '0;
            end
            ST_INVAL: begin
                n_valid = '0;
            end
            ST_UPDATE: begin
                if (r_found) begin
                    wr_cnt_en     = 1'b1;
                    wr_addr       = r_found_idx;
                    wr_cnt        = (r_found_cnt == COUNT_MAX) ? r_found_cnt
                                                               : r_found_cnt + COUNT_W'(1);
                    n_res.hit       = 1'b1;
                    n_res.use_count = wr_cnt;
                    n_res_slot      = r_found_idx;
                end else if (r_need_evict && !r_vic_ok) begin
                    n_res.status = STATUS_NO_VIC;
                end else begin
                    evict_here = r_need_evict;
                    if (evict_here) begin
                        n_valid[r_vic_idx] = 1'b0;
                        n_res.evicted      = 1'b1;
                        n_res.evicted_key  = r_vic_key;
                    end
                    // The evicted slot competes with the lowest free one.
                    if (evict_here && (!r_free_ok || (r_vic_idx < r_free_idx))) begin
                        wr_addr = r_vic_idx;
                    end else begin
                        wr_addr = r_free_idx;
                    end
                    if (evict_here || r_free_ok) begin
                        wr_key_en          = 1'b1;
                        wr_cnt_en          = 1'b1;
                        wr_key             = r_key;
                        wr_cnt             = COUNT_W'(1);
                        n_valid[wr_addr]   = 1'b1;
                        ring_push          = 1'b1;
                        n_ring_head        = (r_ring_head == LAST_RING) ? '0
                                                                        : r_ring_head + RHW'(1);
                        if (r_ring_fill != RING_FULL) begin
                            n_ring_fill = r_ring_fill + RFW'(1);
                        end
                        n_res.added     = 1'b1;
                        n_res.use_count = COUNT_W'(1);
                        n_res_slot      = wr_addr;
                    end else begin
                        n_res.status = STATUS_FULL;
                    end
                end
            end
            default: begin
            end
        endcase

        slot_ext   = XW'(n_res_slot);
        n_res.slot = slot_ext[SLOT_W-1:0];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_valid     <= '0;
            r_ring_head <= '0;
            r_ring_fill <= '0;
            r_limit     <= LIMIT_RESET;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_valid     <= n_valid;
            r_ring_head <= n_ring_head;
            r_ring_fill <= n_ring_fill;
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_data;
            end
            if (r_state == ST_DONE && out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_key <= i_in_data.key;
        end
        r_fill       <= n_fill;
        r_found      <= n_found;
        r_found_idx  <= n_found_idx;
        r_found_cnt  <= n_found_cnt;
        r_free_ok    <= n_free_ok;
        r_free_idx   <= n_free_idx;
        r_need_evict <= n_need_evict;
        r_vic_ok     <= n_vic_ok;
        r_vic_idx    <= n_vic_idx;
        r_vic_key    <= n_vic_key;
        r_vic_cnt    <= n_vic_cnt;
        r_res        <= n_res;
        r_res_slot   <= n_res_slot;
        if (r_state == ST_DONE && out_free) begin
            r_out <= r_res;
        end
        if (ring_push) begin
            r_ring[r_ring_head] <= r_key;
        end
    end

    // Key and count memory. The read address is the next walk index, so the
    // registered read data always belongs to the current index.
    always_ff @(posedge i_clk) begin
        if (wr_key_en) begin
            mem_key[wr_addr] <= wr_key;
        end
        if (wr_cnt_en) begin
            mem_cnt[wr_addr] <= wr_cnt;
        end
        r_rd_key <= mem_key[n_idx];
        r_rd_cnt <= mem_cnt[n_idx];
    end

`ifndef NO_ASSERTIONS
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state != ST_IDLE))
        else $error("sequencer stayed idle after a word was accepted");

    a_victim_is_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE && r_vic_ok && !r_found) |-> r_valid[r_vic_idx])
        else $error("victim candidate is not a valid entry");

    a_added_slot_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_res.added) |-> r_valid[r_res_slot])
        else $error("inserted key does not sit in a valid slot");

    a_done_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && out_free) |=> o_out_valid)
        else $error("finished result was not presented");

    a_ring_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ring_push |=> (r_ring_fill != '0))
        else $error("ring fill is zero after a push");
`endif

endmodule

// ===== bench/tb_lfu_cache_tag_policy.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LFU tag table testbench
// Drives command words into the tag table and writes the capacity limit
// between phases. A scoreboard class keeps its own copy of the table, the
// recent ring and the limit. From that copy it predicts every result word
// and compares each field with what the block returns.
// ----------------------------------------------------------------------------
import lfu_pkg::*;

// Scoreboard: a behavioural copy of the tag table plus a queue of the result
// words still owed by the block, oldest first.
class lfu_scoreboard;
    localparam int ROWS        = 16;
    localparam int RING        = 4;
    localparam int MAX_REPORTS = 100;

    logic               row_valid [ROWS];
    logic [KEY_W-1:0]   row_key   [ROWS];
    logic [COUNT_W-1:0] row_count [ROWS];
    logic [KEY_W-1:0]   ring_key  [RING];
    int                 ring_fill;
    int                 ring_head;
    logic [LIMIT_W-1:0] limit;
    t_out_word          due_q [$];

    int errors;
    int results;
    int hits;
    int saturated;
    int inserts;
    int evictions;
    int no_victim;
    int full_store;

    function new();
        foreach (row_valid[i]) row_valid[i] = 1'b0;
        ring_fill  = 0;
        ring_head  = 0;
        limit      = LIMIT_RESET;
        errors     = 0;
        results    = 0;
        hits       = 0;
        saturated  = 0;
        inserts    = 0;
        evictions  = 0;
        no_victim  = 0;
        full_store = 0;
    endfunction

    function void set_limit(logic [LIMIT_W-1:0] v);
        limit = v;
    endfunction

    function int pending();
        return due_q.size();
    endfunction

    function bit in_ring(logic [KEY_W-1:0] k);
        for (int i = 0; i < ring_fill && i < RING; i++)
            if (ring_key[i] == k) return 1'b1;
        return 1'b0;
    endfunction

    // Works out the result of one accepted command word and updates the copy.
    function void note_word(t_in_word w);
        t_out_word r;
        int        fill;
        int        found;
        int        victim;
        int        free_row;
        bit        ok;
        r        = '0;
        fill     = 0;
        found    = -1;
        victim   = -1;
        free_row = -1;
        case (w.cmd)
            CMD_ZERO: begin
                foreach (row_count[i]) row_count[i] = '0;
            end
            CMD_INVAL: begin
                // The recent ring survives an invalidate.
                foreach (row_valid[i]) row_valid[i] = 1'b0;
            end
            CMD_ACCESS: begin
                for (int i = 0; i < ROWS; i++) begin
                    if (row_valid[i]) begin
                        fill++;
                        if (row_key[i] == w.key && found < 0) found = i;
                    end
                end
                if (found >= 0) begin
                    if (row_count[found] != '1)
                        row_count[found] = row_count[found] + COUNT_W'(1);
                    else
                        saturated++;
                    r.hit       = 1'b1;
                    r.slot      = found[SLOT_W-1:0];
                    r.use_count = row_count[found];
                    hits++;
                end else begin
                    ok = 1'b1;
                    if (limit != 0 && fill >= int'(limit)) begin
                        for (int i = 0; i < ROWS; i++) begin
                            if (!row_valid[i] || in_ring(row_key[i])) continue;
                            if (victim < 0 || row_count[i] < row_count[victim] ||
                                (row_count[i] == row_count[victim] &&
                                 row_key[i] < row_key[victim]))
                                victim = i;
                        end
                        if (victim < 0) begin
                            ok       = 1'b0;
                            r.status = STATUS_NO_VIC;
                            no_victim++;
                        end else begin
                            row_valid[victim] = 1'b0;
                            r.evicted         = 1'b1;
                            r.evicted_key     = row_key[victim];
                            evictions++;
                        end
                    end
                    if (ok) begin
                        for (int i = 0; i < ROWS; i++) begin
                            if (!row_valid[i]) begin
                                free_row = i;
                                break;
                            end
                        end
                        if (free_row < 0) begin
                            r.status = STATUS_FULL;
                            full_store++;
                        end else begin
                            row_valid[free_row] = 1'b1;
                            row_key[free_row]   = w.key;
                            row_count[free_row] = COUNT_W'(1);
                            ring_key[ring_head] = w.key;
                            ring_head           = (ring_head + 1) % RING;
                            if (ring_fill < RING) ring_fill++;
                            r.added     = 1'b1;
                            r.slot      = free_row[SLOT_W-1:0];
                            r.use_count = COUNT_W'(1);
                            inserts++;
                        end
                    end
                end
            end
            default: ;
        endcase
        due_q = {due_q, r};
    endfunction

    function void cmp_field(string name, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    function void check_word(t_out_word got);
        t_out_word want;
        results++;
        if (due_q.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: result word with none due, expected nothing, actual %h",
                         $time, got);
            return;
        end
        want = due_q[0];
        due_q.delete(0);
        cmp_field("hit",         KEY_W'(want.hit),       KEY_W'(got.hit));
        cmp_field("added",       KEY_W'(want.added),     KEY_W'(got.added));
        cmp_field("slot",        KEY_W'(want.slot),      KEY_W'(got.slot));
        cmp_field("evicted",     KEY_W'(want.evicted),   KEY_W'(got.evicted));
        cmp_field("evicted_key", want.evicted_key,       got.evicted_key);
        cmp_field("use_count",   KEY_W'(want.use_count), KEY_W'(got.use_count));
        cmp_field("status",      KEY_W'(want.status),    KEY_W'(got.status));
    endfunction
endclass

module tb_lfu_cache_tag_policy;

    // The package has no name for the spare command code.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Cycles to let pass after the last result before touching the limit or
    // ending the run; the slowest word is a miss with eviction.
    localparam int SETTLE = 40;

    // Back-to-back hits on one key in the closing stretch.
    localparam int HOT_HITS = 72;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    t_in_word           in_word;
    logic               out_valid;
    logic               out_ready;
    t_out_word          out_word;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [LIMIT_W-1:0] cfg_limit;

    // Random stalls on both sides; switched off for the closing stretch.
    bit                 idle_on = 1'b1;
    int                 limit_writes = 0;

    lfu_scoreboard      sb = new();

    lfu_cache_tag_policy i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_limit)
    );

    // 10 ns clock.
    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Generous ceiling on run time. The slowest correct run is roughly 1 250
    // words plus stalls, about 0.6 ms; this gives about five times that.
    initial begin : watchdog
        #3_000_000;
        $display("lfu_cache_tag_policy regression: fail");
        $finish;
    end

    // Result side: ready is driven at the falling edge, and idles in random
    // bursts. A word is taken at a rising edge with valid and ready both high,
    // and is checked there against the oldest prediction.
    initial begin : result_side
        int stall;
        stall     = 0;
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall > 0) begin
                out_ready = 1'b0;
                stall--;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                out_ready = 1'b0;
                stall     = $urandom_range(0, 2);
            end else begin
                out_ready = 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && out_ready)
            sb.check_word(out_word);
    end

    // Offers one command word, at times after a random gap, and returns at
    // the rising edge that accepted it. Valid is left high so that a following
    // word can take over at the next falling edge without a dip.
    task automatic send_word(input logic [1:0] cmd, input logic [KEY_W-1:0] key);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_word.cmd = cmd;
        in_word.key = key;
        in_valid    = 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_word(in_word);
    endtask

    // Waits until every predicted result has arrived and the block has had
    // time to settle, then writes the capacity limit.
    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
        cfg_limit = v;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_limit(v);
        limit_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // One random phase under a given limit. Most words are accesses drawn from
    // a small pool of keys, with the draw skewed so that a few keys build up
    // high counts; the rest are fresh keys and the other commands.
    task automatic run_phase(input logic [LIMIT_W-1:0] lim, input int n);
        logic [KEY_W-1:0] pool [32];
        int               pool_n;
        int               pick;
        logic [4:0]       pick_idx;
        logic [1:0]       cmd;
        logic [KEY_W-1:0] key;
        write_limit(lim);
        pool_n = $urandom_range(6, 28);
        for (int i = 0; i < pool_n; i++) pool[i] = $urandom;
        if ($urandom_range(0, 1)) pool[0] = '0;
        if ($urandom_range(0, 1)) pool[1] = '1;
        for (int j = 0; j < n; j++) begin
            pick = $urandom_range(0, 99);
            key  = $urandom;
            if (pick < 86) begin
                cmd      = CMD_ACCESS;
                pick_idx = 5'($urandom_range(0, $urandom_range(0, pool_n - 1)));
                key      = pool[pick_idx];
            end else if (pick < 90) begin
                cmd = CMD_ACCESS;
            end else if (pick < 94) begin
                cmd = CMD_ZERO;
            end else if (pick < 97) begin
                cmd = CMD_INVAL;
            end else begin
                cmd = CMD_UNUSED;
            end
            send_word(cmd, key);
        end
    endtask

    initial begin : stimulus
        logic [LIMIT_W-1:0] phase_limits [12];
        logic [KEY_W-1:0]   hot_key;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_word   = '0;
        cfg_valid = 1'b0;
        cfg_limit = LIMIT_RESET;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, under the reset limit of 16: both key extremes, a hit,
        // zeroing of the counts, the spare code, and an invalidate that leaves
        // the recent ring holding keys that are no longer stored.
        send_word(CMD_ACCESS, 32'h0000_0000);
        send_word(CMD_ACCESS, 32'hFFFF_FFFF);
        send_word(CMD_ACCESS, 32'h0000_0000);
        send_word(CMD_ZERO,   32'h1234_5678);
        send_word(CMD_ACCESS, 32'h0000_0000);
        send_word(CMD_UNUSED, 32'hFFFF_FFFF);
        send_word(CMD_INVAL,  32'h0000_0000);
        send_word(CMD_ACCESS, 32'hFFFF_FFFF);

        // A limit of two, with both stored keys still in the recent ring, so
        // that the second miss finds no victim.
        write_limit(5'd2);
        send_word(CMD_ACCESS, 32'hA5A5_A5A5);
        send_word(CMD_ACCESS, 32'h5A5A_5A5A);

        // No limit: fill the table and then miss once more on a full store.
        write_limit(5'd0);
        for (int i = 0; i < 15; i++)
            send_word(CMD_ACCESS, 32'h0000_1000 + i * 32'h0101_0101);

        // Back to 16 on a full table: the next miss evicts the smallest key
        // among the lowest counts outside the ring.
        write_limit(5'd16);
        send_word(CMD_ACCESS, 32'hC0DE_0001);

        // Random phases, the limit extremes among them; 31 and 17 lie above
        // the table size and behave as no limit at all.
        phase_limits = '{5'd16, 5'd4, 5'd1, 5'd0, 5'd8, 5'd31,
                         5'd17, 5'd5, 5'd2, 5'd12, 5'd0, 5'd0};
        phase_limits[10] = LIMIT_W'($urandom_range(0, 31));
        phase_limits[11] = LIMIT_W'($urandom_range(0, 31));
        foreach (phase_limits[p])
            run_phase(phase_limits[p], 96);

        // Closing stretch without stalls: hit one key over and over, back to
        // back, so that its count climbs steadily.
        idle_on = 1'b0;
        write_limit(5'd16);
        hot_key = $urandom;
        send_word(CMD_INVAL, hot_key);
        send_word(CMD_ACCESS, hot_key);
        for (int i = 0; i < HOT_HITS; i++)
            send_word(CMD_ACCESS, hot_key);

        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (sb.pending() != 0) begin
            sb.errors++;
            $display("%0t: %0d result words never arrived", $time, sb.pending());
        end

        $display("Checked %0d result words: %0d hits (%0d on a saturated count), %0d inserts.",
                 sb.results, sb.hits, sb.saturated, sb.inserts);
        $display("Saw %0d evictions, %0d misses without a victim, %0d on a full store, %0d limits.",
                 sb.evictions, sb.no_victim, sb.full_store, limit_writes);
        if (sb.errors == 0) begin
            $display("lfu_cache_tag_policy regression: pass");
        end else begin
            $display("lfu_cache_tag_policy regression: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/lfu_pkg.sv
hdl/lfu_cache_tag_policy.sv
bench/tb_lfu_cache_tag_policy.sv
